// ===== hdl/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg
// Types, phase codes and character helpers shared by the number list parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowX   = 8'h78;
  localparam logic [7:0] CharUpX    = 8'h58;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  typedef enum logic [2:0] {
    PhLead,
    PhZero,
    PhPrefix,
    PhDollar,
    PhDigits,
    PhTrail
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       bad_token;
    logic       list_done;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic       hex_base;
    logic [7:0] accumulator;
    logic       discarding;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:       PhLead,
    hex_base:    1'b0,
    accumulator: 8'h00,
    discarding:  1'b0
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  // digit value in the low four bits, bit 4 set when the character is no digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = {1'b0, 4'(c - 8'h37)};
    end
    return d;
  endfunction

  // acc * base + d, modulo 256, base 16 or 10 by shifts
  function automatic logic [7:0] mac_digit(input logic [7:0] acc, input logic hex,
                                           input logic [3:0] d);
    logic [7:0] scaled;
    scaled = hex ? (acc << 4) : ((acc << 3) + (acc << 1));
    return scaled + {4'h0, d};
  endfunction

  function automatic logic token_bad(input phase_e ph);
    return (ph == PhLead) || (ph == PhPrefix);
  endfunction

endpackage

// ===== hdl/csvp_step.sv =====
// ----------------------------------------------------------------------------
// csvp_step
// Next parser state and optional result for one character.
// ----------------------------------------------------------------------------
module csvp_step (
  input  csvp_pkg::parse_state_t st_i,
  input  csvp_pkg::in_item_t     item_i,
  output csvp_pkg::parse_state_t st_o,
  output logic                   emit_o,
  output csvp_pkg::out_item_t    res_o
);
  import csvp_pkg::*;

  logic         ws;
  logic [4:0]   dig;
  logic         is_dig;
  logic         ok;
  logic         bad;
  parse_state_t cons;
  parse_state_t cleared;

  assign ws     = is_space(item_i.ch);
  assign dig    = hex_digit(item_i.ch);
  assign is_dig = !dig[4];

  // consume a non-comma character
  always_comb begin
    cons = st_i;
    ok   = 1'b1;
    unique case (st_i.phase)
      PhLead: begin
        if (ws) begin
          ok = 1'b1;
        end else if (item_i.ch == CharDollar) begin
          cons.hex_base = 1'b1;
          cons.phase    = PhDollar;
        end else if (item_i.ch == CharZero) begin
          cons.accumulator = 8'h00;
          cons.phase       = PhZero;
        end else if (is_dig) begin
          cons.hex_base    = 1'b0;
          cons.accumulator = {4'h0, dig[3:0]};
          cons.phase       = PhDigits;
        end else begin
          ok = 1'b0;
        end
      end
      PhZero: begin
        if ((item_i.ch == CharLowX) || (item_i.ch == CharUpX)) begin
          cons.phase = PhPrefix;
        end else if (ws) begin
          cons.phase = PhTrail;
        end else if (is_dig) begin
          cons.accumulator = mac_digit(st_i.accumulator, st_i.hex_base, dig[3:0]);
          cons.phase       = PhDigits;
        end else begin
          ok = 1'b0;
        end
      end
      PhPrefix: begin
        if (is_dig) begin
          cons.hex_base    = 1'b1;
          cons.accumulator = mac_digit(st_i.accumulator, 1'b1, dig[3:0]);
          cons.phase       = PhDigits;
        end else begin
          ok = 1'b0;
        end
      end
      PhDollar, PhDigits: begin
        if (ws) begin
          cons.phase = PhTrail;
        end else if (is_dig) begin
          cons.accumulator = mac_digit(st_i.accumulator, st_i.hex_base, dig[3:0]);
          cons.phase       = PhDigits;
        end else begin
          ok = 1'b0;
        end
      end
      PhTrail: begin
        ok = ws;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cleared            = StateReset;
    st_o               = st_i;
    emit_o             = 1'b0;
    res_o.value        = 8'h00;
    res_o.bad_token    = 1'b1;
    res_o.list_done    = 1'b1;
    bad                = 1'b0;
    if (st_i.discarding) begin
      if (item_i.end_of_text) begin
        st_o = StateReset;
      end
    end else if (item_i.ch == CharComma) begin
      bad             = token_bad(st_i.phase);
      emit_o          = 1'b1;
      res_o.value     = bad ? 8'h00 : st_i.accumulator;
      res_o.bad_token = bad;
      res_o.list_done = item_i.end_of_text || bad;
      cleared.discarding = bad && !item_i.end_of_text;
      st_o            = cleared;
    end else if (!ok) begin
      emit_o             = 1'b1;
      cleared.discarding = !item_i.end_of_text;
      st_o               = cleared;
    end else if (item_i.end_of_text) begin
      bad             = token_bad(cons.phase);
      emit_o          = 1'b1;
      res_o.value     = bad ? 8'h00 : cons.accumulator;
      res_o.bad_token = bad;
      st_o            = StateReset;
    end else begin
      st_o = cons;
    end
  end

endmodule

// ===== hdl/csvp_out_stage.sv =====
// ----------------------------------------------------------------------------
// csvp_out_stage
// Result register with valid/stall handshake towards the consumer.
// ----------------------------------------------------------------------------
module csvp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  csvp_pkg::out_item_t item_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvp_pkg::out_item_t out_item_o
);
  import csvp_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign room_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== hdl/csv_byte_list_parser_core.sv =====
// ----------------------------------------------------------------------------
// csv_byte_list_parser_core
// Streaming parser for a comma-separated list of byte values, one character
// per item, one byte result per token.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i/in_stall_o    in_item_i  (ch, end_of_text)
//   out      out  out_valid_o/out_stall_i  out_item_o (value, bad_token, list_done)
//
// one item per cycle while no stalled result holds the input; a result is
// presented once its character has passed the input register, then the result register
// the parser state updates when a character leaves the input register
// reset clears the parser state and both valid flags
// a stalled result holds the input only when the next character yields a result
// ----------------------------------------------------------------------------
module csv_byte_list_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csvp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvp_pkg::out_item_t out_item_o
);
  import csvp_pkg::*;

  logic         in_valid_q, in_valid_d;
  in_item_t     in_item_q;
  parse_state_t st_q, st_d;
  logic         emit;
  out_item_t    res;
  logic         room;
  logic         advance;
  logic         accept;

  csvp_step u_step (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .emit_o (emit),
    .res_o  (res)
  );

  csvp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .item_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign advance    = in_valid_q && (!emit || room);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= StateReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

endmodule

// ===== hdl/csvp_checker.sv =====
// ----------------------------------------------------------------------------
// csvp_checker
// Port-level checks on the number list parser, bound to the top level.
// ----------------------------------------------------------------------------
module csvp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input csvp_pkg::out_item_t out_item_o
);
  import csvp_pkg::*;

  // an error result always closes the list and carries zero
  a_bad_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.bad_token) |->
      (out_item_o.list_done && (out_item_o.value == 8'h00)))
    else $error("error result without list_done or with nonzero value");

  // input back-pressure only while a result is held by the consumer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a stalled result stays presented and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed or dropped");

endmodule

bind csv_byte_list_parser_core csvp_checker u_csvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
